// ----- design/tlsche_pkg.sv -----
// ----------------------------------------------------------------------------
// tlsche_pkg
// Shared types, item kinds and protocol constants for the ClientHello
// field extractor.
// ----------------------------------------------------------------------------
package tlsche_pkg;

   localparam int QueueDepth = 4;

   localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
   localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
   localparam logic [15:0] EXT_SNI         = 16'h0000;
   localparam logic [15:0] EXT_GROUPS      = 16'h000a;
   localparam logic [15:0] EXT_POINT_FMTS  = 16'h000b;
   localparam logic [15:0] EXT_SIG_ALGS    = 16'h000d;
   localparam logic [15:0] EXT_ALPN        = 16'h0010;
   localparam logic [15:0] EXT_VERSIONS    = 16'h002b;
   localparam logic [3:0]  NIBBLE_MASK     = 4'hF;
   localparam logic [3:0]  GREASE_NIBBLE   = 4'hA;

   localparam logic [3:0] KIND_VERSION   = 4'd0;
   localparam logic [3:0] KIND_CIPHER    = 4'd1;
   localparam logic [3:0] KIND_EXT_TYPE  = 4'd2;
   localparam logic [3:0] KIND_GROUP     = 4'd3;
   localparam logic [3:0] KIND_POINT_FMT = 4'd4;
   localparam logic [3:0] KIND_SIG_ALG   = 4'd5;
   localparam logic [3:0] KIND_SUP_VER   = 4'd6;
   localparam logic [3:0] KIND_SNI       = 4'd7;
   localparam logic [3:0] KIND_ALPN      = 4'd8;
   localparam logic [3:0] KIND_END       = 4'd9;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  field_kind;
      logic [15:0] field_value;
      logic [16:0] text_offset;
      logic [15:0] text_length;
      logic        parse_status;
      logic        message_done;
   } rsp_type;

   typedef struct packed {
      logic    s0_valid;
      rsp_type s0;
      logic    s1_valid;
      rsp_type s1;
   } push_type;

   function automatic logic grease_code(input logic [15:0] v);
      grease_code = (v[11:8] == GREASE_NIBBLE) && (v[3:0] == GREASE_NIBBLE)
                    && (v[15:8] == v[7:0]);
   endfunction

endpackage

// ----- design/tls_client_hello_field_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// tls_client_hello_field_extractor_unit
// Walks a captured TLS record byte by byte and reports ClientHello fields.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while req_ready is high, and its items enter
// the result queue at the accepting edge, so the first result is offered in
// the following cycle. A byte yields at most a field item plus, on the final
// byte, the end item; the four-entry result queue drains one item per cycle
// and holds req_ready low while fewer than two entries are free. With the
// result side always ready, the sustained rate is one byte per cycle with no
// hold: a double push only happens on a final byte, and the header bytes of
// the next record push no field item, so the queue never fills.
module tls_client_hello_field_extractor_unit #(
   parameter int QueueDepth = tlsche_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tlsche_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tlsche_pkg::rsp_type rsp_data
);
   import tlsche_pkg::*;

   push_type push;
   logic     take;

   assign take = req_valid && req_ready;

   tlsche_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_data),
      .push     (push)
   );

   tlsche_out_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/tlsche_parser.sv -----
// ----------------------------------------------------------------------------
// tlsche_parser
// Byte-wide ClientHello walker: one accepted byte per cycle, up to one field
// item plus the end item per byte.
// ----------------------------------------------------------------------------
module tlsche_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  tlsche_pkg::req_type req_data,
   output tlsche_pkg::push_type push
);
   import tlsche_pkg::*;

   typedef enum logic [4:0] {
      PH_HDR = 5'd0, PH_VER = 5'd1, PH_RANDOM = 5'd2, PH_SIDLEN = 5'd3,
      PH_SID = 5'd4, PH_CSLEN = 5'd5, PH_CIPHER = 5'd6, PH_COMPLEN = 5'd7,
      PH_COMP = 5'd8, PH_EXTSLEN = 5'd9, PH_EXTHDR = 5'd10, PH_SKIP = 5'd11,
      PH_SNI_LIST = 5'd12, PH_SNI_TYPE = 5'd13, PH_SNI_NLEN = 5'd14,
      PH_LIST_LEN = 5'd15, PH_U16_LIST = 5'd16, PH_BYTE_LIST = 5'd17,
      PH_ALPN_LIST = 5'd18, PH_ALPN_LEN = 5'd19, PH_ALPN_STR = 5'd20,
      PH_DONE = 5'd21, PH_FAIL = 5'd22
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [16:0] pos_ff, pos_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [16:0] hs_end_ff, hs_end_in;
   logic [16:0] sec_end_ff, sec_end_in;
   logic [16:0] exts_end_ff, exts_end_in;
   logic [15:0] ext_kind_ff, ext_kind_in;
   logic [16:0] ext_end_ff, ext_end_in;
   logic [16:0] list_end_ff, list_end_in;
   logic [23:0] acc_ff, acc_in;
   logic [7:0]  alpn_char_ff, alpn_char_in;
   logic        failed_ff, failed_in;

   logic [7:0]  b;
   logic [23:0] acc;
   logic [17:0] p, p1, t, hs, sec, ee, le, elen, n, lim;
   logic        fval;
   rsp_type     fitem, eitem;
   logic        go_cs, go_comp, go_exts, go_ext, go_alpn, hdr1, bad;

   always_comb begin
      b = req_data.data_byte;
      acc = {acc_ff[15:0], b};
      p = {1'b0, pos_ff};
      p1 = p + 18'd1;
      hs = {1'b0, hs_end_ff};
      sec = {1'b0, sec_end_ff};
      ee = {1'b0, ext_end_ff};
      le = {1'b0, list_end_ff};
      elen = ee - sec;
      t = '0;
      n = '0;
      lim = '0;
      hdr1 = 1'b0;
      bad = 1'b0;
      go_cs = 1'b0;
      go_comp = 1'b0;
      go_exts = 1'b0;
      go_ext = 1'b0;
      go_alpn = 1'b0;
      fval = 1'b0;
      fitem = '0;
      eitem = '0;
      phase_in = phase_ff;
      pos_in = pos_ff;
      rlen_in = rlen_ff;
      hs_end_in = hs_end_ff;
      sec_end_in = sec_end_ff;
      exts_end_in = exts_end_ff;
      ext_kind_in = ext_kind_ff;
      ext_end_in = ext_end_ff;
      list_end_in = list_end_ff;
      acc_in = acc_ff;
      alpn_char_in = alpn_char_ff;
      failed_in = failed_ff;

      case (phase_ff)
         PH_HDR: begin
            acc_in = acc;
            if (pos_ff == 17'd0 && b != REC_HANDSHAKE) begin
               failed_in = 1'b1; phase_in = PH_FAIL;
            end else begin
               if (pos_ff == 17'd3 || pos_ff == 17'd4) rlen_in = {rlen_ff[7:0], b};
               if (pos_ff == 17'd5 && b != HS_CLIENT_HELLO) begin
                  failed_in = 1'b1; phase_in = PH_FAIL;
               end else begin
                  if (pos_ff == 17'd5) acc_in = '0;
                  if (pos_ff == 17'd8) begin
                     if ({1'b0, acc} + 25'd4 > {9'd0, rlen_in}) begin
                        failed_in = 1'b1; phase_in = PH_FAIL;
                     end else begin
                        hs_end_in = 17'(acc + 24'd9);
                        if (17'd11 > hs_end_in) begin
                           failed_in = 1'b1; phase_in = PH_FAIL;
                        end else begin
                           phase_in = PH_VER; sec_end_in = 17'd11; acc_in = '0;
                        end
                     end
                  end
               end
            end
         end
         PH_VER: begin
            acc_in = acc;
            if (p1 == sec) begin
               fval = 1'b1;
               fitem.field_kind = KIND_VERSION;
               fitem.field_value = acc[15:0];
               t = p + 18'd33;
               sec_end_in = t[16:0];
               if (t > hs) begin
                  failed_in = 1'b1; phase_in = PH_FAIL;
               end else phase_in = PH_RANDOM;
            end
         end
         PH_RANDOM: begin
            if (p1 == sec) begin
               if (p + 18'd2 > hs) begin
                  failed_in = 1'b1; phase_in = PH_FAIL;
               end else phase_in = PH_SIDLEN;
            end
         end
         PH_SIDLEN: begin
            t = p1 + {10'd0, b};
            if (t > hs) begin
               failed_in = 1'b1; phase_in = PH_FAIL;
            end else if (b == 8'd0) go_cs = 1'b1;
            else begin
               phase_in = PH_SID; sec_end_in = t[16:0];
            end
         end
         PH_SID: go_cs = (p1 == sec);
         PH_CSLEN: begin
            acc_in = acc;
            if (p1 == sec) begin
               n = {2'd0, acc[15:0]};
               t = p1 + n;
               if (n[0] || t > hs) begin
                  failed_in = 1'b1; phase_in = PH_FAIL;
               end else if (n == 18'd0) go_comp = 1'b1;
               else begin
                  phase_in = PH_CIPHER; sec_end_in = t[16:0]; acc_in = '0;
               end
            end
         end
         PH_CIPHER: begin
            acc_in = acc;
            if ((sec_end_ff[0] ^ pos_ff[0]) && !grease_code(acc[15:0])) begin
               fval = 1'b1;
               fitem.field_kind = KIND_CIPHER;
               fitem.field_value = acc[15:0];
            end
            go_comp = (p1 == sec);
         end
         PH_COMPLEN: begin
            t = p1 + {10'd0, b};
            if (t > hs) begin
               failed_in = 1'b1; phase_in = PH_FAIL;
            end else if (b == 8'd0) go_exts = 1'b1;
            else begin
               phase_in = PH_COMP; sec_end_in = t[16:0];
            end
         end
         PH_COMP: go_exts = (p1 == sec);
         PH_EXTSLEN: begin
            acc_in = acc;
            if (p1 == sec) begin
               t = p1 + {2'd0, acc[15:0]};
               if (t > hs) begin
                  failed_in = 1'b1; phase_in = PH_FAIL;
               end else begin
                  exts_end_in = t[16:0]; go_ext = 1'b1;
               end
            end
         end
         PH_EXTHDR: begin
            acc_in = acc;
            if (p + 18'd3 == sec) ext_kind_in = acc[15:0];
            if (p1 == sec) begin
               n = {2'd0, acc[15:0]};
               t = p1 + n;
               if (t > {1'b0, exts_end_ff}) phase_in = PH_DONE;
               else begin
                  if (!grease_code(ext_kind_ff)) begin
                     fval = 1'b1;
                     fitem.field_kind = KIND_EXT_TYPE;
                     fitem.field_value = ext_kind_ff;
                  end
                  ext_end_in = t[16:0];
                  sec_end_in = p1[16:0];
                  acc_in = '0;
                  case (ext_kind_ff)
                     EXT_SNI: phase_in = (n >= 18'd5) ? PH_SNI_LIST : PH_SKIP;
                     EXT_GROUPS, EXT_SIG_ALGS:
                        phase_in = (n >= 18'd2) ? PH_LIST_LEN : PH_SKIP;
                     EXT_POINT_FMTS, EXT_VERSIONS:
                        phase_in = (n >= 18'd1) ? PH_LIST_LEN : PH_SKIP;
                     EXT_ALPN: phase_in = (n >= 18'd2) ? PH_ALPN_LIST : PH_SKIP;
                     default: phase_in = PH_SKIP;
                  endcase
               end
            end
         end
         PH_SNI_LIST: begin
            acc_in = acc;
            if (p == sec + 18'd1) begin
               n = {2'd0, acc[15:0]};
               if (n + 18'd2 > elen) phase_in = PH_SKIP;
               else begin
                  list_end_in = n[16:0]; phase_in = PH_SNI_TYPE;
               end
            end
         end
         PH_SNI_TYPE: begin
            if (b != 8'd0) phase_in = PH_SKIP;
            else begin
               phase_in = PH_SNI_NLEN; acc_in = '0;
            end
         end
         PH_SNI_NLEN: begin
            acc_in = acc;
            if (p == sec + 18'd4) begin
               n = {2'd0, acc[15:0]};
               if (le >= 18'd3 && n <= le - 18'd3 && n <= elen - 18'd5) begin
                  fval = 1'b1;
                  fitem.field_kind = KIND_SNI;
                  fitem.text_offset = p1[16:0];
                  fitem.text_length = n[15:0];
               end
               phase_in = PH_SKIP;
            end
         end
         PH_LIST_LEN: begin
            acc_in = acc;
            hdr1 = (ext_kind_ff == EXT_POINT_FMTS) || (ext_kind_ff == EXT_VERSIONS);
            if (p1 == sec + (hdr1 ? 18'd1 : 18'd2)) begin
               n = hdr1 ? {10'd0, acc[7:0]} : {2'd0, acc[15:0]};
               lim = elen - (hdr1 ? 18'd1 : 18'd2);
               if (n > lim) n = lim;
               if (ext_kind_ff != EXT_POINT_FMTS) n[0] = 1'b0;
               if (n == 18'd0) phase_in = PH_SKIP;
               else begin
                  t = p1 + n;
                  list_end_in = t[16:0];
                  phase_in = (ext_kind_ff == EXT_POINT_FMTS) ? PH_BYTE_LIST : PH_U16_LIST;
                  acc_in = '0;
               end
            end
         end
         PH_U16_LIST: begin
            acc_in = acc;
            if ((list_end_ff[0] ^ pos_ff[0]) && !grease_code(acc[15:0])) begin
               fval = 1'b1;
               fitem.field_kind = (ext_kind_ff == EXT_GROUPS) ? KIND_GROUP :
                                  (ext_kind_ff == EXT_SIG_ALGS) ? KIND_SIG_ALG : KIND_SUP_VER;
               fitem.field_value = acc[15:0];
            end
            if (p1 >= le) phase_in = PH_SKIP;
         end
         PH_BYTE_LIST: begin
            fval = 1'b1;
            fitem.field_kind = KIND_POINT_FMT;
            fitem.field_value = {8'd0, b};
            if (p1 >= le) phase_in = PH_SKIP;
         end
         PH_ALPN_LIST: begin
            acc_in = acc;
            if (p == sec + 18'd1) begin
               n = {2'd0, acc[15:0]};
               if (n + 18'd2 > elen) phase_in = PH_SKIP;
               else begin
                  t = p1 + n;
                  list_end_in = t[16:0];
                  go_alpn = 1'b1;
               end
            end
         end
         PH_ALPN_LEN: begin
            t = p1 + {10'd0, b};
            if (b == 8'd0 || t > ee) phase_in = PH_SKIP;
            else begin
               acc_in = {6'd0, p1};
               sec_end_in = t[16:0];
               phase_in = PH_ALPN_STR;
            end
         end
         PH_ALPN_STR: begin
            if ({6'd0, p} == acc_ff) alpn_char_in = b;
            if (p1 == sec) begin
               n = sec - acc_ff[17:0];
               if (n == 18'd2 && alpn_char_in == b && b[3:0] == GREASE_NIBBLE) go_alpn = 1'b1;
               else begin
                  fval = 1'b1;
                  fitem.field_kind = KIND_ALPN;
                  fitem.text_offset = acc_ff[16:0];
                  fitem.text_length = n[15:0];
                  phase_in = PH_SKIP;
               end
            end
         end
         default: ;
      endcase

      if (go_cs) begin
         if (p1 + 18'd2 > hs) begin
            failed_in = 1'b1; phase_in = PH_FAIL;
         end else begin
            t = p1 + 18'd2;
            phase_in = PH_CSLEN; sec_end_in = t[16:0]; acc_in = '0;
         end
      end
      if (go_comp) begin
         if (p1 + 18'd1 > hs) begin
            failed_in = 1'b1; phase_in = PH_FAIL;
         end else phase_in = PH_COMPLEN;
      end
      if (go_exts) begin
         if (p1 + 18'd2 > hs) phase_in = PH_DONE;
         else begin
            t = p1 + 18'd2;
            phase_in = PH_EXTSLEN; sec_end_in = t[16:0]; acc_in = '0;
         end
      end
      if (go_alpn) begin
         if (p1 >= {1'b0, list_end_in} || p1 >= ee) phase_in = PH_SKIP;
         else phase_in = PH_ALPN_LEN;
      end
      if (go_ext || (phase_in >= PH_SKIP && phase_in <= PH_ALPN_STR
                     && p1 >= {1'b0, ext_end_in})) begin
         if (p1 + 18'd4 > {1'b0, exts_end_in}) phase_in = PH_DONE;
         else begin
            t = p1 + 18'd4;
            phase_in = PH_EXTHDR; sec_end_in = t[16:0]; acc_in = '0;
         end
      end

      if (pos_ff != '1) pos_in = pos_ff + 17'd1;

      if (req_data.last_byte) begin
         bad = failed_in || phase_in == PH_HDR || p1 < 18'd5 + {2'd0, rlen_in};
         eitem.field_kind = KIND_END;
         eitem.parse_status = bad;
         eitem.message_done = 1'b1;
         phase_in = PH_HDR;
         pos_in = '0;
         rlen_in = '0;
         hs_end_in = '0;
         sec_end_in = '0;
         exts_end_in = '0;
         ext_kind_in = '0;
         ext_end_in = '0;
         list_end_in = '0;
         acc_in = '0;
         alpn_char_in = '0;
         failed_in = 1'b0;
      end

      push.s0_valid = take && (fval || req_data.last_byte);
      push.s0 = fval ? fitem : eitem;
      push.s1_valid = take && fval && req_data.last_byte;
      push.s1 = eitem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         pos_ff <= '0;
         rlen_ff <= '0;
         hs_end_ff <= '0;
         sec_end_ff <= '0;
         exts_end_ff <= '0;
         ext_kind_ff <= '0;
         ext_end_ff <= '0;
         list_end_ff <= '0;
         acc_ff <= '0;
         alpn_char_ff <= '0;
         failed_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         rlen_ff <= rlen_in;
         hs_end_ff <= hs_end_in;
         sec_end_ff <= sec_end_in;
         exts_end_ff <= exts_end_in;
         ext_kind_ff <= ext_kind_in;
         ext_end_ff <= ext_end_in;
         list_end_ff <= list_end_in;
         acc_ff <= acc_in;
         alpn_char_ff <= alpn_char_in;
         failed_ff <= failed_in;
      end
   end

endmodule

// ----- design/tlsche_out_queue.sv -----
// ----------------------------------------------------------------------------
// tlsche_out_queue
// Small result queue: takes up to two items per cycle, hands out one.
// ----------------------------------------------------------------------------
module tlsche_out_queue #(
   parameter int Depth = tlsche_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tlsche_pkg::push_type push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tlsche_pkg::rsp_type  rsp_data
);
   import tlsche_pkg::*;

   localparam int AW = $clog2(Depth);
   localparam int CW = $clog2(Depth + 1);

   rsp_type         mem_ff [Depth];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in, wr1;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            pop;

   always_comb begin
      pop = rsp_valid && rsp_ready;
      wr1 = wr_ff + AW'(1);
      wr_in = wr_ff + AW'(push.s0_valid) + AW'(push.s1_valid);
      rd_in = rd_ff + AW'(pop);
      cnt_in = cnt_ff + CW'(push.s0_valid) + CW'(push.s1_valid) - CW'(pop);
   end

   assign room = cnt_ff <= CW'(Depth - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push.s0_valid) mem_ff[wr_ff] <= push.s0;
      if (push.s1_valid) mem_ff[wr1] <= push.s1;
   end

endmodule

// ----- design/tlsche_checker.sv -----
// ----------------------------------------------------------------------------
// tlsche_checker
// Port-level checks on the result channel of the field extractor.
// ----------------------------------------------------------------------------
module tlsche_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input tlsche_pkg::rsp_type rsp_data
);
   import tlsche_pkg::*;

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result valid dropped");

   a_done_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.message_done |-> rsp_data.field_kind == KIND_END)
      else $error("done flag on a field item");

   a_field_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.field_kind != KIND_END |->
         !rsp_data.parse_status && !rsp_data.message_done)
      else $error("status on a field item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");

endmodule

bind tls_client_hello_field_extractor_unit tlsche_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
